>>> rtl/dhfpc_pkg.sv
// shared types and constants for the dual hall flow pulse counter
`default_nettype none

package dhfpc_pkg;

   localparam int unsigned FLOW_W   = 32;
   localparam int unsigned REPEAT_W = 4;

   localparam logic [REPEAT_W-1:0] REPEAT_MAX      = 4'd15;
   localparam logic [REPEAT_W-1:0] THRESHOLD_RESET = 4'd3;

   // event kind carried in the func field
   localparam logic FUNC_HALL = 1'b0;
   localparam logic FUNC_WAKE = 1'b1;

   typedef enum logic [1:0] {
      FAULT_NONE         = 2'd0,
      FAULT_INTERFERENCE = 2'd1,
      FAULT_SENSOR1_STUCK = 2'd2,
      FAULT_SENSOR2_STUCK = 2'd3
   } fault_type;

   typedef enum logic {
      PHASE_EXPECT_ONE = 1'b0,
      PHASE_EXPECT_TWO = 1'b1
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      fault_type             fault;
      logic [REPEAT_W-1:0]   repeat_count;
      logic [FLOW_W-1:0]     pulse_total;
   } state_type;

   typedef struct packed {
      logic func;
      logic hall1_low;
      logic hall2_low;
      logic wake_low;
   } event_type;

endpackage

`default_nettype wire

>>> rtl/dhfpc_step.sv
// next-state and report logic for one sensor word
`default_nettype none

module dhfpc_step (
   input  dhfpc_pkg::state_type              cur_state,
   input  dhfpc_pkg::event_type              evt,
   input  logic [dhfpc_pkg::REPEAT_W-1:0]    threshold,
   output dhfpc_pkg::state_type              nxt_state,
   output logic                              report
);

   logic [dhfpc_pkg::REPEAT_W-1:0] count_bumped;
   dhfpc_pkg::fault_type           stuck_code;

   // saturating repeat count and the stuck code of the repeated sensor
   assign count_bumped = (cur_state.repeat_count == dhfpc_pkg::REPEAT_MAX) ?
                         dhfpc_pkg::REPEAT_MAX :
                         cur_state.repeat_count + 1'b1;
   assign stuck_code   = evt.hall1_low ? dhfpc_pkg::FAULT_SENSOR1_STUCK :
                                         dhfpc_pkg::FAULT_SENSOR2_STUCK;

   always_comb begin
      nxt_state = cur_state;
      report    = 1'b0;
      priority if (evt.func == dhfpc_pkg::FUNC_WAKE) begin
         report = evt.wake_low;
      end else if (evt.hall1_low && evt.hall2_low) begin
         // both active: magnetic interference
         if (cur_state.fault != dhfpc_pkg::FAULT_INTERFERENCE) begin
            nxt_state.fault        = dhfpc_pkg::FAULT_INTERFERENCE;
            nxt_state.repeat_count = '0;
            report                 = 1'b1;
         end
      end else if (evt.hall1_low || evt.hall2_low) begin
         if (cur_state.phase == dhfpc_pkg::PHASE_EXPECT_ONE && evt.hall1_low) begin
            nxt_state.phase        = dhfpc_pkg::PHASE_EXPECT_TWO;
            nxt_state.fault        = dhfpc_pkg::FAULT_NONE;
            nxt_state.repeat_count = '0;
         end else if (cur_state.phase == dhfpc_pkg::PHASE_EXPECT_TWO &&
                      evt.hall2_low) begin
            // full pulse completed
            nxt_state.phase        = dhfpc_pkg::PHASE_EXPECT_ONE;
            nxt_state.fault        = dhfpc_pkg::FAULT_NONE;
            nxt_state.repeat_count = '0;
            nxt_state.pulse_total  = cur_state.pulse_total + 1'b1;
         end else begin
            // same sensor again
            nxt_state.repeat_count = count_bumped;
            if (count_bumped >= threshold && cur_state.fault != stuck_code) begin
               nxt_state.fault = stuck_code;
               report          = 1'b1;
            end
         end
      end else begin
         // no sensor active: state stays as it is and no report is raised
         nxt_state = cur_state;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dual_hall_flow_pulse_counter_unit.sv
// top level of the dual hall flow pulse counter
//
//   channel  | ports  | direction | contents
//   ---------+--------+-----------+------------------------------------------
//   request  | req_*  | in        | func, hall1_low, hall2_low, wake_low,
//            |        |           | modem_down
//   response | rsp_*  | out       | flow_count, fault_code, report_request,
//            |        |           | reconnect_request
//   config   | csr_*  | in        | repeat_threshold, write only
//
// one word in, one word out; the response shows up the cycle after accept
// state is updated in the same cycle the request word is accepted
// a new word is taken every cycle while the response register is empty
// or being drained; a stalled response holds the request side off
// synchronous active-high reset clears the state, threshold goes to 3
`default_nettype none

module dual_hall_flow_pulse_counter_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic        req_hall1_low,
   input  logic        req_hall2_low,
   input  logic        req_wake_low,
   input  logic        req_modem_down,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_flow_count,
   output logic [1:0]  rsp_fault_code,
   output logic        rsp_report_request,
   output logic        rsp_reconnect_request,

   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   // architectural state
   dhfpc_pkg::state_type           state_ff;
   dhfpc_pkg::state_type           state_in;
   logic [dhfpc_pkg::REPEAT_W-1:0] threshold_ff;

   // response register
   logic                           rsp_valid_ff;
   logic [dhfpc_pkg::FLOW_W-1:0]   flow_ff;
   dhfpc_pkg::fault_type           fault_ff;
   logic                           report_ff;
   logic                           reconnect_ff;

   dhfpc_pkg::event_type           evt;
   logic                           report;
   logic                           accept;

   // request side waits only while a finished word is held
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign evt.func      = req_func;
   assign evt.hall1_low = req_hall1_low;
   assign evt.hall2_low = req_hall2_low;
   assign evt.wake_low  = req_wake_low;

   dhfpc_step u_step (
      .cur_state (state_ff),
      .evt       (evt),
      .threshold (threshold_ff),
      .nxt_state (state_in),
      .report    (report)
   );

   // state and threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= dhfpc_pkg::PHASE_EXPECT_ONE;
         state_ff.fault        <= dhfpc_pkg::FAULT_NONE;
         state_ff.repeat_count <= '0;
         state_ff.pulse_total  <= '0;
         threshold_ff          <= dhfpc_pkg::THRESHOLD_RESET;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload, loaded with the post-event state
   always_ff @(posedge clock) begin
      if (accept) begin
         flow_ff      <= state_in.pulse_total;
         fault_ff     <= state_in.fault;
         report_ff    <= report;
         reconnect_ff <= report && req_modem_down;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_flow_count        = flow_ff;
   assign rsp_fault_code        = 2'(fault_ff);
   assign rsp_report_request    = report_ff;
   assign rsp_reconnect_request = reconnect_ff;

   // reconnect is only ever asked together with a report
   a_reconnect_needs_report : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff && reconnect_ff |-> report_ff)
      else $error("reconnect without report");

   // an accepted word always leaves a response behind
   a_accept_gives_rsp : assert property (
      @(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   // state moves only when a word is accepted
   a_state_holds : assert property (
      @(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("state changed without an accepted word");

   // flow count advances by at most one per word
   a_flow_step : assert property (
      @(posedge clock) disable iff (reset)
      accept |=> (state_ff.pulse_total == $past(state_ff.pulse_total)) ||
                 (state_ff.pulse_total == $past(state_ff.pulse_total) + 32'd1))
      else $error("flow count jumped");

endmodule

`default_nettype wire
